FILE: rtl/stsd_pkg.sv
// Shared constants, state encodings and defaults for the sphere triangle subdivider.
package stsd_pkg;

    // parameter defaults
    localparam int STSD_MAX_DEPTH  = 3;
    localparam int STSD_COORD_BITS = 16;

    // configuration register reset value
    localparam logic [1:0] CFG_DEPTH_RST = 2'd1;

    // normalizer datapath: magnitudes live on a 16-bit scale
    localparam int MAG_W  = 17;    // |vi+vj| on the 16-bit scale, up to 2^16
    localparam int SQ_W   = 33;    // one squared magnitude
    localparam int LEN_W  = 34;    // sum of three squares
    localparam int Q_W    = 15;    // Q.14 root magnitude, 0..16384
    localparam int T_W    = 16;    // trial value before the range check
    localparam int DSQ_W  = 30;    // (2t-1)^2
    localparam int LEN_LO = 17;    // split point of the length for the wide product
    localparam int PP_W   = DSQ_W + LEN_LO;
    localparam int PROD_W = 64;    // product kept modulo 2^64
    localparam logic [T_W-1:0] Q_ONE = T_W'(16384);
    localparam logic [3:0]     TOP_BIT = 4'd14;

    // sequencer of the back end
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RDP,
        S_MID,
        S_MIDW,
        S_WR,
        S_WAITO,
        S_RDO
    } t_bstate;

    // midpoint normalizer
    typedef enum logic [3:0] {
        N_IDLE,
        N_SQ,
        N_ACC,
        N_TGT,
        N_DSQ,
        N_PLO,
        N_PHI,
        N_CMP,
        N_FIN
    } t_nstate;

    // child digits
    localparam logic [1:0] CH_V1  = 2'd0;
    localparam logic [1:0] CH_V2  = 2'd1;
    localparam logic [1:0] CH_V3  = 2'd2;
    localparam logic [1:0] CH_MID = 2'd3;

endpackage

FILE: rtl/stsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/stsd_norm.sv
// Midpoint normalizer: (p+q)/|p+q| per component by a bitwise root search.
module stsd_norm #(
    parameter int COORD_BITS = stsd_pkg::STSD_COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [3*COORD_BITS-1:0] i_p,
    input  logic [3*COORD_BITS-1:0] i_q,
    output logic                    o_done,
    output logic [3*COORD_BITS-1:0] o_r
);
    import stsd_pkg::*;

    localparam int CB = COORD_BITS;

    t_nstate r_state, n_state;

    logic [MAG_W-1:0]  r_mag [3];
    logic [2:0]        r_neg;
    logic [LEN_W-1:0]  r_len2;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_tsq;
    logic [1:0]        r_c;
    logic [3:0]        r_bit;
    logic [Q_W-1:0]    r_q;
    logic [DSQ_W-1:0]  r_dsq;
    logic [PP_W-1:0]   r_plo;
    logic [PP_W-1:0]   r_phi;
    logic [CB-1:0]     r_res [3];
    logic              r_done;

    logic [MAG_W-1:0]  w_mag [3];
    logic [2:0]        w_neg;
    logic [T_W-1:0]    w_t;
    logic              w_tok;
    logic [Q_W-1:0]    w_d;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_target;
    logic [LEN_W-1:0]  w_len_sum;
    logic [CB-1:0]     w_res;

    // sums and magnitudes brought to the 16-bit scale
    always_comb begin
        logic signed [CB:0] s;
        logic [CB:0]        sa;
        logic [CB+16:0]     wide;
        for (int c = 0; c < 3; c++) begin
            s = $signed({i_p[(2-c)*CB+CB-1], i_p[(2-c)*CB +: CB]})
              + $signed({i_q[(2-c)*CB+CB-1], i_q[(2-c)*CB +: CB]});
            w_neg[c] = s[CB];
            sa = s[CB] ? (~s + 1'b1) : s;
            wide = {sa, 16'b0};
            w_mag[c] = wide[CB+16:CB];
        end
    end

    // trial value, its odd square and the wrapped product against the target
    always_comb begin
        logic [T_W:0] d2;
        w_t   = {1'b0, r_q} + (T_W'(1) << r_bit);
        w_tok = (w_t <= Q_ONE);
        d2    = {w_t, 1'b0} - 1'b1;
        w_d   = d2[Q_W-1:0];
        w_prod   = PROD_W'(r_plo) + {r_phi, 17'b0};
        w_target = PROD_W'({r_tsq, 30'b0});
        w_len_sum = r_len2 + LEN_W'(r_sq);
    end

    // final scaling of the root to the coordinate format, sign applied last
    always_comb begin
        logic [CB+14:0] qx;
        logic [CB-2:0]  mg;
        qx = {r_q, {CB{1'b0}}};
        mg = qx[CB+14:16];
        w_res = r_neg[r_c] ? (~{1'b0, mg} + 1'b1) : {1'b0, mg};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE: if (i_start) n_state = N_SQ;
            N_SQ:   n_state = N_ACC;
            N_ACC: begin
                if (r_c == 2'd2) begin
                    n_state = (w_len_sum == '0) ? N_IDLE : N_TGT;
                end else begin
                    n_state = N_SQ;
                end
            end
            N_TGT:  n_state = N_DSQ;
            N_DSQ: begin
                if (w_tok) begin
                    n_state = N_PLO;
                end else if (r_bit == '0) begin
                    n_state = N_FIN;
                end
            end
            N_PLO:  n_state = N_PHI;
            N_PHI:  n_state = N_CMP;
            N_CMP:  n_state = (r_bit == '0) ? N_FIN : N_DSQ;
            N_FIN:  n_state = (r_c == 2'd2) ? N_IDLE : N_TGT;
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == N_ACC) && (r_c == 2'd2) && (w_len_sum == '0))
                    || ((r_state == N_FIN) && (r_c == 2'd2));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int c = 0; c < 3; c++) begin
                        r_mag[c] <= w_mag[c];
                    end
                    r_neg  <= w_neg;
                    r_len2 <= '0;
                    r_c    <= 2'd0;
                end
            end
            N_SQ: r_sq <= SQ_W'(r_mag[r_c] * r_mag[r_c]);
            N_ACC: begin
                r_len2 <= w_len_sum;
                if (r_c == 2'd2) begin
                    r_c <= 2'd0;
                    if (w_len_sum == '0) begin
                        for (int c = 0; c < 3; c++) begin
                            r_res[c] <= '0;
                        end
                    end
                end else begin
                    r_c <= r_c + 2'd1;
                end
            end
            N_TGT: begin
                r_tsq <= SQ_W'(r_mag[r_c] * r_mag[r_c]);
                r_q   <= '0;
                r_bit <= TOP_BIT;
            end
            N_DSQ: begin
                if (w_tok) begin
                    r_dsq <= DSQ_W'(w_d * w_d);
                end else if (r_bit != '0) begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            N_PLO: r_plo <= PP_W'(r_dsq * r_len2[LEN_LO-1:0]);
            N_PHI: r_phi <= PP_W'(r_dsq * r_len2[LEN_W-1:LEN_LO]);
            N_CMP: begin
                if (w_prod <= w_target) begin
                    r_q <= w_t[Q_W-1:0];
                end
                if (r_bit != '0) begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            N_FIN: begin
                r_res[r_c] <= w_res;
                if (r_c != 2'd2) begin
                    r_c <= r_c + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_r    = {r_res[0], r_res[1], r_res[2]};

    // a new request never lands on a busy normalizer
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == N_IDLE))
        else $error("normalizer started while busy");
    // the root search only runs on a nonzero length
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == N_DSQ) |-> (r_len2 != '0))
        else $error("root search on zero length");
    // done follows the last component or the zero-length shortcut
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == N_FIN || $past(r_state) == N_ACC))
        else $error("spurious normalizer done");
endmodule

FILE: rtl/stsd_front.sv
// Front end: accepts triangles, fixes their depth and queues them for the back end.
module stsd_front #(
    parameter int COORD_BITS = stsd_pkg::STSD_COORD_BITS,
    parameter int MAX_DEPTH  = stsd_pkg::STSD_MAX_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [9*COORD_BITS-1:0]             i_tri,
    input  logic [1:0]                          i_depth_cfg,
    output logic                                o_valid,
    output logic [9*COORD_BITS-1:0]             o_tri,
    output logic [$clog2(MAX_DEPTH+1)-1:0]      o_depth,
    input  logic                                i_pop
);
    import stsd_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int TW = 9 * COORD_BITS;

    logic [TW-1:0] r_tri   [2];
    logic [LW-1:0] r_depth [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;
    logic [LW-1:0] w_depth;

    // depth beyond the supported levels saturates
    assign w_depth = (int'(i_depth_cfg) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(i_depth_cfg);

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_cnt != 2'd0);

    // two-entry request queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_tri[r_wr]   <= i_tri;
            r_depth[r_wr] <= w_depth;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_tri   = r_tri[r_rd];
    assign o_depth = r_depth[r_rd];

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty queue");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");
endmodule

FILE: rtl/stsd_back.sv
// Back end: walks the leaf triangles depth-first and drives the result register.
module stsd_back #(
    parameter int COORD_BITS = stsd_pkg::STSD_COORD_BITS,
    parameter int MAX_DEPTH  = stsd_pkg::STSD_MAX_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [9*COORD_BITS-1:0]        i_q_tri,
    input  logic [$clog2(MAX_DEPTH+1)-1:0] i_q_depth,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [9*COORD_BITS-1:0]        o_out_tri,
    output logic                           o_last
);
    import stsd_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int VW = 3 * CB;
    localparam int TW = 9 * CB;
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int KW = 2 * MAX_DEPTH;
    localparam int RD = (MAX_DEPTH + 1) * 3;
    localparam int AW = $clog2(RD);

    t_bstate r_state, n_state;

    logic [TW-1:0] r_item;
    logic [LW-1:0] r_depth;
    logic [LW-1:0] r_lvl;
    logic [KW-1:0] r_k;
    logic [1:0]    r_v;
    logic [1:0]    r_j;
    logic [VW-1:0] r_p0, r_p1, r_p2;
    logic [VW-1:0] r_m12, r_m23, r_m31;
    logic          r_ov;
    logic [TW-1:0] r_otri;
    logic          r_olast;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [VW-1:0] w_wdata, w_rdata;
    logic          w_nstart, w_ndone;
    logic [VW-1:0] w_np, w_nq, w_nr;
    logic [1:0]    w_digit;
    logic [KW-1:0] w_knext;
    logic [LW-1:0] w_start;
    logic          w_last;
    logic [1:0]    w_vi;

    // level vertex store: entry = level * 3 + vertex
    stsd_ram #(.WIDTH(VW), .DEPTH(RD)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    stsd_norm #(.COORD_BITS(CB)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_nstart),
        .i_p     (w_np),
        .i_q     (w_nq),
        .o_done  (w_ndone),
        .o_r     (w_nr)
    );

    // digit of the current leaf at this level, and leaf bookkeeping
    always_comb begin
        logic [KW-1:0] sh;
        logic [KW-1:0] mask;
        logic          found;
        logic [LW-1:0] tz;
        sh      = r_k >> {r_depth - r_lvl, 1'b0};
        w_digit = sh[1:0];
        mask    = ~({KW{1'b1}} << {r_depth, 1'b0});
        w_last  = (r_k == mask);
        w_knext = r_k + 1'b1;
        found   = 1'b0;
        tz      = '0;
        // levels whose digit did not change keep their stored triangle
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (!found && (w_knext[2*i +: 2] == 2'd0)) begin
                tz = tz + 1'b1;
            end else begin
                found = 1'b1;
            end
        end
        w_start = r_depth - tz;
    end

    // store addressing
    always_comb begin
        logic [LW-1:0] rl;
        w_vi = (r_v == 2'd3) ? 2'd0 : r_v;
        rl   = (r_state == S_RDO) ? r_depth : (r_lvl - 1'b1);
        w_raddr = AW'({rl, 1'b0}) + AW'(rl) + AW'(w_vi);
        w_waddr = AW'({r_lvl, 1'b0}) + AW'(r_lvl) + AW'(w_vi);
        w_we    = (r_state == S_LOAD) || (r_state == S_WR);
        if (r_state == S_LOAD) begin
            w_wdata = r_item[(2 - w_vi) * VW +: VW];
        end else begin
            w_wdata = r_m12;
            case (w_digit)
                CH_V1:   w_wdata = (w_vi == 2'd0) ? r_p0 : (w_vi == 2'd1) ? r_m12 : r_m31;
                CH_V2:   w_wdata = (w_vi == 2'd0) ? r_p1 : (w_vi == 2'd1) ? r_m23 : r_m12;
                CH_V3:   w_wdata = (w_vi == 2'd0) ? r_p2 : (w_vi == 2'd1) ? r_m31 : r_m23;
                CH_MID:  w_wdata = (w_vi == 2'd0) ? r_m12 : (w_vi == 2'd1) ? r_m23 : r_m31;
                default: w_wdata = r_m12;
            endcase
        end
    end

    // edge pair for the normalizer
    always_comb begin
        case (r_j)
            2'd0:    begin w_np = r_p0; w_nq = r_p1; end
            2'd1:    begin w_np = r_p1; w_nq = r_p2; end
            default: begin w_np = r_p2; w_nq = r_p0; end
        endcase
    end

    assign w_nstart = (r_state == S_MID);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_LOAD;
            S_LOAD: begin
                if (r_v == 2'd2) begin
                    n_state = (r_depth == '0) ? S_WAITO : S_RDP;
                end
            end
            S_RDP:  if (r_v == 2'd3) n_state = S_MID;
            S_MID:  n_state = S_MIDW;
            S_MIDW: begin
                if (w_ndone) begin
                    n_state = (r_j == 2'd2) ? S_WR : S_MID;
                end
            end
            S_WR: begin
                if (r_v == 2'd2) begin
                    n_state = (r_lvl == r_depth) ? S_WAITO : S_RDP;
                end
            end
            S_WAITO: if (!r_ov) n_state = S_RDO;
            S_RDO: begin
                if (r_v == 2'd3) begin
                    n_state = w_last ? S_IDLE : S_RDP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_lvl   <= '0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end else if ((r_state == S_RDO) && (r_v == 2'd3)) begin
                r_ov <= 1'b1;
            end
            if (o_q_pop) begin
                r_depth <= i_q_depth;
                r_lvl   <= '0;
            end else if ((r_state == S_LOAD) && (r_v == 2'd2)) begin
                r_lvl <= (r_depth == '0) ? '0 : LW'(1);
            end else if ((r_state == S_WR) && (r_v == 2'd2) && (r_lvl != r_depth)) begin
                r_lvl <= r_lvl + 1'b1;
            end else if ((r_state == S_RDO) && (r_v == 2'd3) && !w_last) begin
                r_lvl <= w_start;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_q_tri;
                    r_v    <= 2'd0;
                end
            end
            S_LOAD: begin
                if (r_v == 2'd2) begin
                    r_k <= '0;
                    r_v <= 2'd0;
                end else begin
                    r_v <= r_v + 2'd1;
                end
            end
            S_RDP: begin
                case (r_v)
                    2'd1:    r_p0 <= w_rdata;
                    2'd2:    r_p1 <= w_rdata;
                    2'd3:    r_p2 <= w_rdata;
                    default: ;
                endcase
                if (r_v == 2'd3) begin
                    r_j <= 2'd0;
                end else begin
                    r_v <= r_v + 2'd1;
                end
            end
            S_MIDW: begin
                if (w_ndone) begin
                    case (r_j)
                        2'd0:    r_m12 <= w_nr;
                        2'd1:    r_m23 <= w_nr;
                        default: r_m31 <= w_nr;
                    endcase
                    if (r_j == 2'd2) begin
                        r_v <= 2'd0;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            S_WR: begin
                r_v <= (r_v == 2'd2) ? 2'd0 : r_v + 2'd1;
            end
            S_WAITO: r_v <= 2'd0;
            S_RDO: begin
                if (r_v != 2'd0) begin
                    r_otri[(3 - r_v) * VW +: VW] <= w_rdata;
                end
                if (r_v == 2'd3) begin
                    r_olast <= w_last;
                    r_k     <= w_knext;
                    r_v     <= 2'd0;
                end else begin
                    r_v <= r_v + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_tri   = r_otri;
    assign o_last      = r_olast;

    // the result register is only refilled once it has drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDO) |-> !r_ov)
        else $error("result register overwritten");
    // midpoints arrive only while the sequencer waits for them
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ndone |-> (r_state == S_MIDW))
        else $error("unexpected midpoint");
    // the working level never passes the item's depth
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lvl <= r_depth))
        else $error("level beyond depth");
endmodule

FILE: rtl/sphere_triangle_subdivider_unit.sv
// Top level of the geodesic sphere triangle subdivider.
// Each request is one triangle of three Q2.14 vertices; it is split
// subdivision_depth times (0..3, reset 1, saturating at MAX_DEPTH) into
// 4^depth leaf triangles, emitted depth-first with o_last_leaf on the final
// one. Midpoints are renormalized to the unit sphere by one shared bitwise
// root-search normalizer, which sets the throughput: it works one result bit
// at a time for each of three components, and each recomputed level needs
// three midpoints plus store traffic. Only levels whose child digit changes
// are recomputed. A two-entry request queue and a result register let
// input and output stall independently of the walk.
module sphere_triangle_subdivider_unit #(
    parameter int MAX_DEPTH  = stsd_pkg::STSD_MAX_DEPTH,
    parameter int COORD_BITS = stsd_pkg::STSD_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_out_a_x,
    output logic signed [COORD_BITS-1:0] o_out_a_y,
    output logic signed [COORD_BITS-1:0] o_out_a_z,
    output logic signed [COORD_BITS-1:0] o_out_b_x,
    output logic signed [COORD_BITS-1:0] o_out_b_y,
    output logic signed [COORD_BITS-1:0] o_out_b_z,
    output logic signed [COORD_BITS-1:0] o_out_c_x,
    output logic signed [COORD_BITS-1:0] o_out_c_y,
    output logic signed [COORD_BITS-1:0] o_out_c_z,
    output logic                         o_last_leaf
);
    import stsd_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int LW = $clog2(MAX_DEPTH + 1);

    logic [1:0]      r_depth_cfg;
    logic [9*CB-1:0] w_in_tri, w_q_tri, w_out_tri;
    logic            w_q_valid, w_q_pop;
    logic [LW-1:0]   w_q_depth;

    // depth register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_cfg <= CFG_DEPTH_RST;
        end else if (i_cfg_we) begin
            r_depth_cfg <= i_cfg_data;
        end
    end

    assign w_in_tri = {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z};

    stsd_front #(.COORD_BITS(CB), .MAX_DEPTH(MAX_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_tri       (w_in_tri),
        .i_depth_cfg (r_depth_cfg),
        .o_valid     (w_q_valid),
        .o_tri       (w_q_tri),
        .o_depth     (w_q_depth),
        .i_pop       (w_q_pop)
    );

    stsd_back #(.COORD_BITS(CB), .MAX_DEPTH(MAX_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_tri     (w_q_tri),
        .i_q_depth   (w_q_depth),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_tri   (w_out_tri),
        .o_last      (o_last_leaf)
    );

    assign o_out_a_x = w_out_tri[8*CB +: CB];
    assign o_out_a_y = w_out_tri[7*CB +: CB];
    assign o_out_a_z = w_out_tri[6*CB +: CB];
    assign o_out_b_x = w_out_tri[5*CB +: CB];
    assign o_out_b_y = w_out_tri[4*CB +: CB];
    assign o_out_b_z = w_out_tri[3*CB +: CB];
    assign o_out_c_x = w_out_tri[2*CB +: CB];
    assign o_out_c_y = w_out_tri[1*CB +: CB];
    assign o_out_c_z = w_out_tri[0 +: CB];
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the sphere triangle subdivider.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stsd_pkg::*;

    localparam int  LIMIT_CYCLES = 60_000_000;
    localparam int  DRAIN_CYCLES = 64;
    localparam logic signed [15:0] Q_UNIT = 16'sd16384;

    typedef longint vec3_t [3];

    // one leaf triangle: nine coordinates a_x..c_z, then the last flag
    typedef struct packed {
        logic [8:0][15:0] crd;
        logic             last;
    } leaf_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic signed [15:0] i_crd [9];
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [15:0] o_crd [9];
    logic        o_last_leaf;

    initial for (int i = 0; i < 9; i++) i_crd[i] = '0;

    always #10 i_clk = ~i_clk;

    sphere_triangle_subdivider_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_a_x(i_crd[0]), .i_a_y(i_crd[1]), .i_a_z(i_crd[2]),
        .i_b_x(i_crd[3]), .i_b_y(i_crd[4]), .i_b_z(i_crd[5]),
        .i_c_x(i_crd[6]), .i_c_y(i_crd[7]), .i_c_z(i_crd[8]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_a_x(o_crd[0]), .o_out_a_y(o_crd[1]), .o_out_a_z(o_crd[2]),
        .o_out_b_x(o_crd[3]), .o_out_b_y(o_crd[4]), .o_out_b_z(o_crd[5]),
        .o_out_c_x(o_crd[6]), .o_out_c_y(o_crd[7]), .o_out_c_z(o_crd[8]),
        .o_last_leaf(o_last_leaf)
    );

    // predictor state
    logic [1:0] depth_shadow = CFG_DEPTH_RST;
    leaf_t      leaf_queue [$];
    longint     level_tri [4][3][3];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         leaf_count = 0;
    int         tri_count = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;

    // midpoint of two vertices, renormalized onto the unit sphere
    function automatic void sphere_midpoint(input vec3_t p, input vec3_t q,
                                            output vec3_t r);
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned len2, target, qv, b, t, d;
        longint          s;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            s = p[i] + q[i];
            neg[i] = s < 0;
            mag[i] = neg[i] ? longint'(-s) : longint'(s);
            len2 += mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (len2 == 0) begin
                r[i] = 0;
            end else begin
                target = (mag[i] * mag[i]) << 30;
                qv = 0;
                for (b = 64'd1 << 14; b != 0; b >>= 1) begin
                    t = qv + b;
                    if (t <= 16384) begin
                        d = 2 * t - 1;
                        if (d * d * len2 <= target) qv = t;
                    end
                end
                r[i] = neg[i] ? -longint'(qv) : longint'(qv);
            end
        end
    endfunction

    // child triangle at level lvl+1 from its parent and the child digit
    function automatic void split_child(input int lvl, input logic [1:0] digit);
        vec3_t par [3];
        vec3_t m12, m23, m31;
        vec3_t src [3];
        for (int v = 0; v < 3; v++)
            for (int c = 0; c < 3; c++) par[v][c] = level_tri[lvl][v][c];
        sphere_midpoint(par[0], par[1], m12);
        sphere_midpoint(par[1], par[2], m23);
        sphere_midpoint(par[2], par[0], m31);
        case (digit)
            CH_V1: begin src[0] = par[0]; src[1] = m12; src[2] = m31; end
            CH_V2: begin src[0] = par[1]; src[1] = m23; src[2] = m12; end
            CH_V3: begin src[0] = par[2]; src[1] = m31; src[2] = m23; end
            default: begin src[0] = m12; src[1] = m23; src[2] = m31; end
        endcase
        for (int v = 0; v < 3; v++)
            for (int c = 0; c < 3; c++) level_tri[lvl + 1][v][c] = src[v][c];
    endfunction

    // all leaves of one accepted triangle, depth-first
    function automatic void predict_leaves(input logic signed [15:0] tri_in [9]);
        int    dep;
        int    n;
        leaf_t lf;
        dep = (depth_shadow > STSD_MAX_DEPTH) ? STSD_MAX_DEPTH : depth_shadow;
        n = 1 << (2 * dep);
        for (int v = 0; v < 3; v++)
            for (int c = 0; c < 3; c++) level_tri[0][v][c] = tri_in[v * 3 + c];
        for (int k = 0; k < n; k++) begin
            for (int l = 1; l <= dep; l++)
                split_child(l - 1, 2'((k >> (2 * (dep - l))) & 3));
            for (int j = 0; j < 9; j++) lf.crd[j] = 16'(level_tri[dep][j / 3][j % 3]);
            lf.last = (k == n - 1);
            leaf_queue.insert(leaf_queue.size(), lf);
        end
    endfunction

    // send one triangle request and hold it until accepted
    task automatic send_tri(input logic signed [15:0] tri_in [9]);
        int gap;
        i_in_valid <= 1'b1;
        for (int j = 0; j < 9; j++) i_crd[j] <= tri_in[j];
        do @(posedge i_clk); while (o_in_stall);
        predict_leaves(tri_in);
        tri_count++;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // depth write, only with the block drained
    task automatic set_depth(input logic [1:0] dep);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (leaf_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= dep;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        depth_shadow = dep;
    endtask

    // random vertex: mostly near the unit sphere, sometimes raw noise or rails
    function automatic void rand_vertex(output logic signed [15:0] v [3]);
        int sel;
        int ax;
        sel = $urandom_range(9);
        for (int c = 0; c < 3; c++) begin
            case (sel)
                0, 1: v[c] = 16'($urandom);
                2: v[c] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
                default: v[c] = 16'($signed($urandom_range(0, 4096)) - 2048);
            endcase
        end
        if (sel > 2) begin
            ax = $urandom_range(2);
            v[ax] = ($urandom_range(1)) ? Q_UNIT : -Q_UNIT;
        end
    endfunction

    function automatic void rand_tri(output logic signed [15:0] t [9]);
        logic signed [15:0] v [3];
        for (int k = 0; k < 3; k++) begin
            rand_vertex(v);
            for (int c = 0; c < 3; c++) t[k * 3 + c] = v[c];
        end
        // antipodal pair now and then: zero-length midpoint sum
        if ($urandom_range(7) == 0)
            for (int c = 0; c < 3; c++) t[3 + c] = -t[c];
    endfunction

    function automatic void fill_tri(output logic signed [15:0] t [9],
                                     input logic signed [15:0] a0, a1, a2,
                                     input logic signed [15:0] b0, b1, b2,
                                     input logic signed [15:0] c0, c1, c2);
        t[0] = a0; t[1] = a1; t[2] = a2;
        t[3] = b0; t[4] = b1; t[5] = b2;
        t[6] = c0; t[7] = c1; t[8] = c2;
    endfunction

    // stall generator for the result side
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        leaf_t got;
        leaf_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            for (int j = 0; j < 9; j++) got.crd[j] = o_crd[j];
            got.last = o_last_leaf;
            leaf_count++;
            if (leaf_queue.size() == 0) begin
                $display("%0t: unexpected leaf %h", $time, got);
                fail_count++;
            end else begin
                want = leaf_queue.pop_front();
                for (int j = 0; j < 9; j++)
                    if (got.crd[j] !== want.crd[j]) begin
                        $display("%0t: coord %0d expected %0d actual %0d", $time, j,
                                 $signed(want.crd[j]), $signed(got.crd[j]));
                        fail_count++;
                    end
                if (got.last !== want.last) begin
                    $display("%0t: last_leaf expected %b actual %b", $time,
                             want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // reset depth (one level): octant face, antipodal vertices, rails
    task automatic test_reset_depth;
        logic signed [15:0] t [9];
        fill_tri(t, Q_UNIT, 0, 0, 0, Q_UNIT, 0, 0, 0, Q_UNIT);
        send_tri(t);
        fill_tri(t, Q_UNIT, 0, 0, -Q_UNIT, 0, 0, 0, Q_UNIT, 0);
        send_tri(t);
        fill_tri(t, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_tri(t);
        fill_tri(t, 16'sh7fff, 16'sh8000, 0, 16'sh7fff, 16'sh8000, 0, 0, 0, 0);
        send_tri(t);
    endtask

    // depth zero: the input passes through once
    task automatic test_depth_zero;
        logic signed [15:0] t [9];
        set_depth(2'd0);
        fill_tri(t, 16'sh8000, 16'sh7fff, 0, -1, 1, 16'sh8000, 16'sh7fff, 0, -1);
        send_tri(t);
        fill_tri(t, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                 16'sh8000, 0, 0, 0);
        send_tri(t);
        fill_tri(t, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                 16'h5555, 16'haaaa, 16'h5555);
        send_tri(t);
    endtask

    // two and three levels, including a degenerate all-zero face
    task automatic test_deep_levels;
        logic signed [15:0] t [9];
        set_depth(2'd2);
        fill_tri(t, -Q_UNIT, 0, 0, 0, -Q_UNIT, 0, 0, 0, -Q_UNIT);
        send_tri(t);
        fill_tri(t, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tri(t);
        set_depth(2'd3);
        fill_tri(t, Q_UNIT, 0, 0, 0, Q_UNIT, 0, 0, 0, Q_UNIT);
        send_tri(t);
        fill_tri(t, 0, Q_UNIT, 0, 0, -Q_UNIT, 0, Q_UNIT, 0, 0);
        send_tri(t);
    endtask

    // random triangles; depth changes in blocks, deep levels kept rare
    task automatic test_random(input int idle_pct, input int stall_pct,
                               input int n_items);
        logic signed [15:0] t [9];
        int sel;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 10 == 0) begin
                sel = $urandom_range(19);
                set_depth(sel < 6 ? 2'd0 : (sel < 17 ? 2'd1 : 2'd2));
            end
            rand_tri(t);
            send_tri(t);
        end
    endtask

    // a few full-depth random triangles under stall on both sides
    task automatic test_random_full_depth;
        logic signed [15:0] t [9];
        sender_idle_pct = 14;
        receiver_stall_pct = 14;
        set_depth(2'd3);
        for (int i = 0; i < 2; i++) begin
            rand_tri(t);
            send_tri(t);
        end
        set_depth(2'd1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_depth();
        test_depth_zero();
        test_deep_levels();
        test_random(0, 0, 50);
        test_random(71, 0, 50);
        test_random(0, 71, 50);
        test_random(14, 14, 50);
        test_random_full_depth();
        i_in_valid <= 1'b0;
        while (leaf_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d triangles and %0d leaves at depths 0..3,", tri_count,
                 leaf_count);
        $display("with rail, antipodal and random vertices under idle and stall.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
